// ===== rtl/core/kagf_pkg.sv =====
// Package for the angle/gyro Kalman fusion unit.
// Holds format constants, sequencer and operation codes, saturation helpers.
// No dependencies.
package kagf_pkg;

  localparam int ANGLE_W       = 32;
  localparam int COV_W         = 48;
  localparam int COV_FRAC_BITS = 44;
  localparam int DT_FRAC_BITS  = 32;
  localparam int MN_FRAC_BITS  = 28;
  localparam int NOISE_SH      = 64 - COV_FRAC_BITS;
  localparam int MN_SH         = COV_FRAC_BITS - MN_FRAC_BITS;

  // shared multiplier: 50-bit magnitudes as two 25-bit pieces
  localparam int OPW  = 50;
  localparam int PW   = OPW / 2;
  localparam int PPW  = 2 * PW;
  localparam int ACCW = 2 * OPW;
  localparam int RMW  = 51;           // rounded product magnitude
  localparam int RESW = RMW + 1;      // signed product
  localparam int SUMW = RESW + 1;     // accumulate before saturation

  // gain divider, two quotient bits per cycle
  localparam int EW        = 50;      // innovation variance, signed
  localparam int DW        = 49;      // its magnitude
  localparam int DIV_STEPS = COV_W / 2;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic [31:0] PNA_RST = 32'd4294967;
  localparam logic [31:0] PNB_RST = 32'd8589935;
  localparam logic [31:0] MN_RST  = 32'd179851347;
  localparam logic [31:0] DT_RST  = 32'd21474836;

  localparam logic signed [COV_W-1:0] COV_ONE = COV_W'(1) << COV_FRAC_BITS;
  localparam logic signed [COV_W-1:0] COV_MAX = {1'b0, {(COV_W-1){1'b1}}};
  localparam logic signed [COV_W-1:0] COV_MIN = {1'b1, {(COV_W-1){1'b0}}};
  localparam logic signed [ANGLE_W-1:0] ANG_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANG_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_WB,
    ST_DIVS,
    ST_DIVI,
    ST_DIVR,
    ST_DIVF,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_ANG,   // angle predict
    OP_NQA,   // angle process noise
    OP_P00,   // P00 cross term
    OP_P01,   // P01/P10 term
    OP_NQB,   // bias process noise
    OP_C00,
    OP_C01,
    OP_C10,
    OP_C11,
    OP_CB,    // bias correction
    OP_CA     // angle correction
  } op_t;

  typedef enum logic [1:0] {
    SH_NOISE,
    SH_DT,
    SH_COV
  } sh_t;

  typedef enum logic [1:0] {
    CFG_PNA,
    CFG_PNB,
    CFG_MN,
    CFG_DT
  } cfg_idx_t;

  function automatic logic [OPW-1:0] mag50(logic signed [OPW-1:0] v);
    mag50 = v[OPW-1] ? OPW'(-v) : OPW'(v);
  endfunction

  function automatic logic signed [COV_W-1:0] sat_cov(logic signed [SUMW-1:0] v);
    if (v[SUMW-1] && !(&v[SUMW-2:COV_W-1]))
      sat_cov = COV_MIN;
    else if (!v[SUMW-1] && (|v[SUMW-2:COV_W-1]))
      sat_cov = COV_MAX;
    else
      sat_cov = v[COV_W-1:0];
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat_ang(logic signed [SUMW-1:0] v);
    if (v[SUMW-1] && !(&v[SUMW-2:ANGLE_W-1]))
      sat_ang = ANG_MIN;
    else if (!v[SUMW-1] && (|v[SUMW-2:ANGLE_W-1]))
      sat_ang = ANG_MAX;
    else
      sat_ang = v[ANGLE_W-1:0];
  endfunction

endpackage

// ===== rtl/core/kalman_angle_gyro_fusion_unit.sv =====
// Top level of the angle/gyro Kalman fusion unit: sequencer, shared multiplier,
// radix-4 gain divider, filter state and configuration registers.
// Depends on kagf_pkg.
//
// One request carries an accelerometer angle and a gyro rate (Q16.16) and
// yields one result: fused angle and bias-corrected rate. Each request runs
// eleven products on one shared 25x25 multiplier (four partial products, a
// rounding step and a write-back step each) and two gain divisions on a divider
// retiring two quotient bits per cycle. The input side is ready only while the
// sequencer is idle; a finished result waits in the output register while the
// next request is taken. Configuration is written through cfg_we/cfg_index/
// cfg_data; the user must write it only while idle, and the block itself does
// not enforce this.
module kalman_angle_gyro_fusion_unit
  import kagf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] accel_angle, [63:32] gyro_rate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] fused_angle, [63:32] fused_rate
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [DIV_CW-1:0] div_cnt_r, div_cnt_nxt;
  logic div_sel_r, div_sel_nxt;

  logic [31:0] pna_r, pna_nxt, pnb_r, pnb_nxt, mn_r, mn_nxt, dt_r, dt_nxt;

  logic signed [ANGLE_W-1:0] ang_r, ang_nxt, bias_r, bias_nxt;
  logic signed [COV_W-1:0]   p_r [4];
  logic signed [COV_W-1:0]   p_nxt [4];
  logic signed [COV_W-1:0]   pq_r [4];
  logic signed [COV_W-1:0]   pq_nxt [4];
  logic signed [COV_W-1:0]   k0_r, k0_nxt, k1_r, k1_nxt;
  logic signed [SUMW-1:0]    s_r, s_nxt;

  logic signed [ANGLE_W-1:0] accel_r, accel_nxt, gyro_r, gyro_nxt;
  logic [ACCW-1:0]           acc_r, acc_nxt;
  logic signed [RESW-1:0]    res_r, res_nxt;

  logic [DW-1:0]    d_r, d_nxt, rem_r, rem_nxt;
  logic [COV_W-1:0] nq_r, nq_nxt;
  logic e_neg_r, e_neg_nxt, q_neg_r, q_neg_nxt, ovf_r, ovf_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [ANGLE_W-1:0]    out_angle_r, out_angle_nxt, out_rate_r, out_rate_nxt;

  // operand selection
  logic signed [ANGLE_W:0] diff_gb, err;
  logic signed [COV_W:0]   sum01;
  logic [OPW-1:0]          opa, opb;
  logic                    opneg;
  sh_t                     sh;

  // multiplier and rounding
  logic [PW-1:0]   ha, hb;
  logic [PPW-1:0]  pp;
  logic [ACCW-1:0] ppw, rw, rsh;
  logic [RMW-1:0]  rmag;

  // divider
  logic signed [SUMW-1:0]  res_x;
  logic signed [EW-1:0]    e_val;
  logic [OPW-1:0]          e_mag, n_mag;
  logic signed [COV_W-1:0] num;
  logic [DW:0]             r1, r2;
  logic [DW-1:0]           r1s, r2s;
  logic                    b1, b2;
  logic signed [COV_W-1:0] kval;

  logic in_acc, div_last, out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rate_r, out_angle_r};
  assign out_free   = !out_valid_r || out_tready;
  assign div_last   = (div_cnt_r == DIV_CW'(DIV_STEPS - 1));

  assign diff_gb = {gyro_r[ANGLE_W-1], gyro_r} - {bias_r[ANGLE_W-1], bias_r};
  assign err     = {accel_r[ANGLE_W-1], accel_r} - {ang_r[ANGLE_W-1], ang_r};
  assign sum01   = {p_r[1][COV_W-1], p_r[1]} + {p_r[2][COV_W-1], p_r[2]};

  always_comb begin
    opa   = '0;
    opb   = {18'b0, dt_r};
    opneg = 1'b0;
    sh    = SH_DT;
    case (op_r)
      OP_ANG: begin
        opa   = mag50({{17{diff_gb[ANGLE_W]}}, diff_gb});
        opneg = diff_gb[ANGLE_W];
      end
      OP_NQA: begin
        opa = {18'b0, pna_r};
        sh  = SH_NOISE;
      end
      OP_P00: begin
        opa   = mag50({sum01[COV_W], sum01});
        opneg = !sum01[COV_W] && (sum01 != '0);
      end
      OP_P01: begin
        opa   = mag50({{2{p_r[3][COV_W-1]}}, p_r[3]});
        opneg = !p_r[3][COV_W-1] && (p_r[3] != '0);
      end
      OP_NQB: begin
        opa = {18'b0, pnb_r};
        sh  = SH_NOISE;
      end
      OP_C00: begin
        opa   = mag50({{2{k0_r[COV_W-1]}}, k0_r});
        opb   = mag50({{2{pq_r[0][COV_W-1]}}, pq_r[0]});
        opneg = k0_r[COV_W-1] ^ pq_r[0][COV_W-1];
        sh    = SH_COV;
      end
      OP_C01: begin
        opa   = mag50({{2{k0_r[COV_W-1]}}, k0_r});
        opb   = mag50({{2{pq_r[1][COV_W-1]}}, pq_r[1]});
        opneg = k0_r[COV_W-1] ^ pq_r[1][COV_W-1];
        sh    = SH_COV;
      end
      OP_C10: begin
        opa   = mag50({{2{k1_r[COV_W-1]}}, k1_r});
        opb   = mag50({{2{pq_r[0][COV_W-1]}}, pq_r[0]});
        opneg = k1_r[COV_W-1] ^ pq_r[0][COV_W-1];
        sh    = SH_COV;
      end
      OP_C11: begin
        opa   = mag50({{2{k1_r[COV_W-1]}}, k1_r});
        opb   = mag50({{2{pq_r[1][COV_W-1]}}, pq_r[1]});
        opneg = k1_r[COV_W-1] ^ pq_r[1][COV_W-1];
        sh    = SH_COV;
      end
      OP_CB: begin
        opa   = mag50({{2{k1_r[COV_W-1]}}, k1_r});
        opb   = mag50({{17{err[ANGLE_W]}}, err});
        opneg = k1_r[COV_W-1] ^ err[ANGLE_W];
        sh    = SH_COV;
      end
      OP_CA: begin
        opa   = mag50({{2{k0_r[COV_W-1]}}, k0_r});
        opb   = mag50({{17{err[ANGLE_W]}}, err});
        opneg = k0_r[COV_W-1] ^ err[ANGLE_W];
        sh    = SH_COV;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  // one partial product per cycle
  assign ha  = cnt_r[0] ? opa[OPW-1:PW] : opa[PW-1:0];
  assign hb  = cnt_r[1] ? opb[OPW-1:PW] : opb[PW-1:0];
  assign pp  = ha * hb;

  always_comb begin
    case (cnt_r)
      2'd0:    ppw = ACCW'(pp);
      2'd3:    ppw = ACCW'(pp) << (2 * PW);
      default: ppw = ACCW'(pp) << PW;
    endcase
  end

  // round half away from zero on the magnitude
  always_comb begin
    case (sh)
      SH_NOISE: begin
        rw  = acc_r + (ACCW'(1) << (NOISE_SH - 1));
        rsh = rw >> NOISE_SH;
      end
      SH_COV: begin
        rw  = acc_r + (ACCW'(1) << (COV_FRAC_BITS - 1));
        rsh = rw >> COV_FRAC_BITS;
      end
      default: begin
        rw  = acc_r + (ACCW'(1) << (DT_FRAC_BITS - 1));
        rsh = rw >> DT_FRAC_BITS;
      end
    endcase
  end
  assign rmag  = rsh[RMW-1:0];
  assign res_x = {res_r[RESW-1], res_r};

  // divider datapath
  assign e_val = {2'b0, mn_r, {MN_SH{1'b0}}} + {{(EW-COV_W){pq_r[0][COV_W-1]}}, pq_r[0]};
  assign e_mag = mag50(e_val);
  assign num   = div_sel_r ? pq_r[2] : pq_r[0];
  assign n_mag = mag50({{2{num[COV_W-1]}}, num});

  assign r1  = {rem_r, nq_r[COV_W-1]};
  assign b1  = (r1 >= {1'b0, d_r});
  assign r1s = b1 ? DW'(r1 - {1'b0, d_r}) : r1[DW-1:0];
  assign r2  = {r1s, nq_r[COV_W-2]};
  assign b2  = (r2 >= {1'b0, d_r});
  assign r2s = b2 ? DW'(r2 - {1'b0, d_r}) : r2[DW-1:0];

  always_comb begin
    if (d_r == '0)
      kval = '0;
    else if (q_neg_r) begin
      if (ovf_r || (nq_r > {1'b1, {(COV_W-1){1'b0}}}))
        kval = COV_MIN;
      else
        kval = -$signed(nq_r);
    end else begin
      if (ovf_r || nq_r[COV_W-1])
        kval = COV_MAX;
      else
        kval = $signed(nq_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_MUL;
      ST_MUL:  if (cnt_r == 2'd3) state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_WB;
      ST_WB: begin
        if (op_r == OP_NQB)
          state_nxt = ST_DIVS;
        else if (op_r == OP_CA)
          state_nxt = ST_DONE;
        else
          state_nxt = ST_MUL;
      end
      ST_DIVS: state_nxt = ST_DIVI;
      ST_DIVI: state_nxt = ST_DIVR;
      ST_DIVR: if (div_last) state_nxt = ST_DIVF;
      ST_DIVF: state_nxt = div_sel_r ? ST_MUL : ST_DIVI;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    div_cnt_nxt   = div_cnt_r;
    div_sel_nxt   = div_sel_r;
    pna_nxt       = pna_r;
    pnb_nxt       = pnb_r;
    mn_nxt        = mn_r;
    dt_nxt        = dt_r;
    ang_nxt       = ang_r;
    bias_nxt      = bias_r;
    p_nxt         = p_r;
    pq_nxt        = pq_r;
    k0_nxt        = k0_r;
    k1_nxt        = k1_r;
    s_nxt         = s_r;
    accel_nxt     = accel_r;
    gyro_nxt      = gyro_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    d_nxt         = d_r;
    rem_nxt       = rem_r;
    nq_nxt        = nq_r;
    e_neg_nxt     = e_neg_r;
    q_neg_nxt     = q_neg_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_angle_nxt = out_angle_r;
    out_rate_nxt  = out_rate_r;

    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PNA: pna_nxt = cfg_data;
        CFG_PNB: pnb_nxt = cfg_data;
        CFG_MN:  mn_nxt  = cfg_data;
        CFG_DT:  dt_nxt  = cfg_data;
        default: pna_nxt = pna_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          accel_nxt = in_tdata[31:0];
          gyro_nxt  = in_tdata[63:32];
          op_nxt    = OP_ANG;
          cnt_nxt   = 2'd0;
        end
      end
      ST_MUL: begin
        acc_nxt = ((cnt_r == 2'd0) ? ACCW'(0) : acc_r) + ppw;
        cnt_nxt = cnt_r + 2'd1;
      end
      ST_RND: begin
        res_nxt = opneg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
      end
      ST_WB: begin
        case (op_r)
          OP_ANG: ang_nxt   = sat_ang({{(SUMW-ANGLE_W){ang_r[ANGLE_W-1]}}, ang_r} + res_x);
          OP_NQA: s_nxt     = {{(SUMW-COV_W){p_r[0][COV_W-1]}}, p_r[0]} + res_x;
          OP_P00: pq_nxt[0] = sat_cov(s_r + res_x);
          OP_P01: begin
            pq_nxt[1] = sat_cov({{(SUMW-COV_W){p_r[1][COV_W-1]}}, p_r[1]} + res_x);
            pq_nxt[2] = sat_cov({{(SUMW-COV_W){p_r[2][COV_W-1]}}, p_r[2]} + res_x);
          end
          OP_NQB: pq_nxt[3] = sat_cov({{(SUMW-COV_W){p_r[3][COV_W-1]}}, p_r[3]} + res_x);
          OP_C00: p_nxt[0]  = sat_cov({{(SUMW-COV_W){pq_r[0][COV_W-1]}}, pq_r[0]} - res_x);
          OP_C01: p_nxt[1]  = sat_cov({{(SUMW-COV_W){pq_r[1][COV_W-1]}}, pq_r[1]} - res_x);
          OP_C10: p_nxt[2]  = sat_cov({{(SUMW-COV_W){pq_r[2][COV_W-1]}}, pq_r[2]} - res_x);
          OP_C11: p_nxt[3]  = sat_cov({{(SUMW-COV_W){pq_r[3][COV_W-1]}}, pq_r[3]} - res_x);
          OP_CB:  bias_nxt  = sat_ang({{(SUMW-ANGLE_W){bias_r[ANGLE_W-1]}}, bias_r} + res_x);
          OP_CA:  ang_nxt   = sat_ang({{(SUMW-ANGLE_W){ang_r[ANGLE_W-1]}}, ang_r} + res_x);
          default: s_nxt    = s_r;
        endcase
        if (op_r != OP_NQB && op_r != OP_CA)
          op_nxt = op_t'(4'(op_r) + 4'd1);
        cnt_nxt = 2'd0;
      end
      ST_DIVS: begin
        d_nxt       = e_mag[DW-1:0];
        e_neg_nxt   = e_val[EW-1];
        div_sel_nxt = 1'b0;
      end
      ST_DIVI: begin
        // quotient fits 48 bits only if the numerator is below 16 * divisor
        ovf_nxt     = ({5'b0, n_mag[COV_W-1:0]} >= {d_r, 4'b0});
        q_neg_nxt   = num[COV_W-1] ^ e_neg_r;
        rem_nxt     = DW'(n_mag[COV_W-1:4]);
        nq_nxt      = {n_mag[3:0], {(COV_W-4){1'b0}}};
        div_cnt_nxt = '0;
      end
      ST_DIVR: begin
        rem_nxt     = r2s;
        nq_nxt      = {nq_r[COV_W-3:0], b1, b2};
        div_cnt_nxt = div_cnt_r + DIV_CW'(1);
      end
      ST_DIVF: begin
        if (div_sel_r) begin
          k1_nxt  = kval;
          op_nxt  = OP_C00;
          cnt_nxt = 2'd0;
        end else begin
          k0_nxt      = kval;
          div_sel_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_angle_nxt = ang_r;
          out_rate_nxt  = sat_ang({{(SUMW-ANGLE_W-1){diff_gb[ANGLE_W]}}, diff_gb});
        end
      end
      default: op_nxt = op_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pna_r       <= PNA_RST;
      pnb_r       <= PNB_RST;
      mn_r        <= MN_RST;
      dt_r        <= DT_RST;
      ang_r       <= '0;
      bias_r      <= '0;
      p_r[0]      <= COV_ONE;
      p_r[1]      <= '0;
      p_r[2]      <= '0;
      p_r[3]      <= COV_ONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pna_r       <= pna_nxt;
      pnb_r       <= pnb_nxt;
      mn_r        <= mn_nxt;
      dt_r        <= dt_nxt;
      ang_r       <= ang_nxt;
      bias_r      <= bias_nxt;
      p_r         <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    cnt_r       <= cnt_nxt;
    div_cnt_r   <= div_cnt_nxt;
    div_sel_r   <= div_sel_nxt;
    pq_r        <= pq_nxt;
    k0_r        <= k0_nxt;
    k1_r        <= k1_nxt;
    s_r         <= s_nxt;
    accel_r     <= accel_nxt;
    gyro_r      <= gyro_nxt;
    acc_r       <= acc_nxt;
    res_r       <= res_nxt;
    d_r         <= d_nxt;
    rem_r       <= rem_nxt;
    nq_r        <= nq_nxt;
    e_neg_r     <= e_neg_nxt;
    q_neg_r     <= q_neg_nxt;
    ovf_r       <= ovf_nxt;
    out_angle_r <= out_angle_nxt;
    out_rate_r  <= out_rate_nxt;
  end

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for kalman_angle_gyro_fusion_unit: directed corners, then random IMU
// sample streams under several noise/step settings, checked against a bit-exact filter model.
// Depends on kagf_pkg and the unit RTL.
`timescale 1ns / 100ps

module testbench;
  import kagf_pkg::*;

  localparam int WIDE_W      = 60;
  localparam int SEG_ITEMS   = 300;
  localparam int SEG_COUNT   = 6;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic signed [31:0] gyro_rate;
    logic signed [31:0] accel_angle;
  } imu_sample_t;

  typedef struct packed {
    logic signed [31:0] fused_rate;
    logic signed [31:0] fused_angle;
  } fused_t;

  class kalman_ledger;
    logic [31:0] noise_angle, noise_bias, meas_noise, step_time;
    longint      angle_est, bias_est;
    longint      cov [4];
    fused_t      fused_due [$];
    int          mismatches;
    int          results_seen;

    function new();
      noise_angle = PNA_RST;
      noise_bias  = PNB_RST;
      meas_noise  = MN_RST;
      step_time   = DT_RST;
      angle_est   = 0;
      bias_est    = 0;
      cov[0] = longint'(1) << COV_FRAC_BITS;
      cov[1] = 0;
      cov[2] = 0;
      cov[3] = longint'(1) << COV_FRAC_BITS;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function logic [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function longint clamp_mag(bit neg, logic [63:0] m, int w);
      logic [63:0] lim;
      lim = (64'd1 << (w - 1)) - (neg ? 64'd0 : 64'd1);
      if (m > lim)
        m = lim;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function longint saturate(longint v, int w);
      return clamp_mag(v < 0, magnitude(v), w);
    endfunction

    // round-half-away product, scaled down by 2^sh
    function longint scaled_product(longint a, longint b, int sh, int w);
      logic [127:0] p;
      p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      return clamp_mag((a < 0) != (b < 0), (p[127:64] != 0) ? '1 : p[63:0], w);
    endfunction

    // num / den in Q4.44, truncated toward zero
    function longint gain(longint num, longint den);
      logic [127:0] q;
      logic [63:0]  d;
      d = magnitude(den);
      if (d == 0)
        return 0;
      q = ({64'd0, magnitude(num)} << COV_FRAC_BITS) / {64'd0, d};
      return clamp_mag((num < 0) != (den < 0), (q[127:64] != 0) ? '1 : q[63:0], COV_W);
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_PNA: noise_angle = v;
        CFG_PNB: noise_bias  = v;
        CFG_MN:  meas_noise  = v;
        CFG_DT:  step_time   = v;
      endcase
    endfunction

    function fused_t predict_fused(imu_sample_t s);
      longint accel, gyro, dt, p00, p01, p10, p11, e, k0, k1, err;
      fused_t f;
      accel = s.accel_angle;
      gyro  = s.gyro_rate;
      dt    = longint'({32'd0, step_time});
      angle_est = saturate(angle_est +
                  scaled_product(gyro - bias_est, dt, DT_FRAC_BITS, WIDE_W), ANGLE_W);
      p00 = saturate(cov[0] + scaled_product({32'd0, noise_angle}, dt, NOISE_SH, WIDE_W)
            + scaled_product(-(cov[1] + cov[2]), dt, DT_FRAC_BITS, WIDE_W), COV_W);
      p01 = saturate(cov[1] + scaled_product(-cov[3], dt, DT_FRAC_BITS, WIDE_W), COV_W);
      p10 = saturate(cov[2] + scaled_product(-cov[3], dt, DT_FRAC_BITS, WIDE_W), COV_W);
      p11 = saturate(cov[3] + scaled_product({32'd0, noise_bias}, dt, NOISE_SH, WIDE_W), COV_W);
      e  = (longint'({32'd0, meas_noise}) << MN_SH) + p00;
      k0 = gain(p00, e);
      k1 = gain(p10, e);
      cov[0] = saturate(p00 - scaled_product(k0, p00, COV_FRAC_BITS, WIDE_W), COV_W);
      cov[1] = saturate(p01 - scaled_product(k0, p01, COV_FRAC_BITS, WIDE_W), COV_W);
      cov[2] = saturate(p10 - scaled_product(k1, p00, COV_FRAC_BITS, WIDE_W), COV_W);
      cov[3] = saturate(p11 - scaled_product(k1, p01, COV_FRAC_BITS, WIDE_W), COV_W);
      err = accel - angle_est;
      angle_est = saturate(angle_est + scaled_product(k0, err, COV_FRAC_BITS, WIDE_W), ANGLE_W);
      bias_est  = saturate(bias_est + scaled_product(k1, err, COV_FRAC_BITS, WIDE_W), ANGLE_W);
      f.fused_angle = angle_est[31:0];
      f.fused_rate  = saturate(gyro - bias_est, ANGLE_W);
      return f;
    endfunction

    function void note_sample(imu_sample_t s);
      fused_due.push_back(predict_fused(s));
    endfunction

    function void note_miss(string field, logic signed [31:0] want, logic signed [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s mismatch at result %0d: expected %0d, got %0d",
                 field, results_seen, want, got);
    endfunction

    function void check_fused(fused_t got);
      fused_t want;
      results_seen++;
      if (fused_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d: angle %0d rate %0d",
                   results_seen, got.fused_angle, got.fused_rate);
        return;
      end
      want = fused_due.pop_front();
      if (got.fused_angle !== want.fused_angle)
        note_miss("fused_angle", want.fused_angle, got.fused_angle);
      if (got.fused_rate !== want.fused_rate)
        note_miss("fused_rate", want.fused_rate, got.fused_rate);
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [31:0] cfg_data   = '0;

  kalman_ledger book;
  int send_idle_pct = 9;
  int recv_idle_pct = 79;
  int stall_left    = 0;
  int cycle_count   = 0;
  int track_angle   = 0;
  int track_rate    = 0;
  int gyro_offset   = 0;

  kalman_angle_gyro_fusion_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side backpressure, with occasional long stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      out_tready <= 1'b0;
      if ($urandom_range(0, 15) == 0)
        stall_left <= $urandom_range(1, 100);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      book.check_fused(out_tdata);

  task automatic send_sample(imu_sample_t s);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 140) : 1;
      repeat (gap) @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    book.note_sample(s);
  endtask

  // stop sending and wait for the unit to drain and go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (book.fused_due.size() != 0 || !in_tready);
  endtask

  task automatic program_regs(logic [31:0] pna, logic [31:0] pnb,
                              logic [31:0] mn, logic [31:0] dt);
    cfg_idx_t    order [4];
    logic [31:0] vals [4];
    order = '{CFG_PNA, CFG_PNB, CFG_MN, CFG_DT};
    vals  = '{pna, pnb, mn, dt};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      book.set_reg(order[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'd1;
      2: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_corner();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return '1;
      default: return 32'd1;
    endcase
  endfunction

  // mostly a plausible slowly moving tilt with a biased gyro
  function automatic imu_sample_t next_sample();
    imu_sample_t s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      if ($urandom_range(0, 49) == 0)
        track_rate = int'($urandom_range(0, 65536000)) - 32768000;
      if ($urandom_range(0, 199) == 0)
        gyro_offset = int'($urandom_range(0, 655360)) - 327680;
      track_angle = track_angle + track_rate / 200;
      if (track_angle > 11796480 || track_angle < -11796480)
        track_angle = -track_angle / 2;
      s.accel_angle = track_angle + int'($urandom_range(0, 393216)) - 196608;
      s.gyro_rate   = track_rate + gyro_offset + int'($urandom_range(0, 65536)) - 32768;
    end else if (pick < 90) begin
      s.accel_angle = $urandom;
      s.gyro_rate   = $urandom;
    end else begin
      s.accel_angle = pick_corner();
      s.gyro_rate   = pick_corner();
    end
    return s;
  endfunction

  initial begin
    logic [31:0] corner_vals [4];
    imu_sample_t s;
    book = new();
    corner_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // field corners at reset settings
    foreach (corner_vals[i])
      foreach (corner_vals[j]) begin
        s.accel_angle = corner_vals[i];
        s.gyro_rate   = corner_vals[j];
        send_sample(s);
      end

    // full-scale noise and step: drives estimates into saturation
    settle();
    program_regs('1, '1, '1, '1);
    for (int i = 0; i < 4; i++) begin
      s.accel_angle = corner_vals[i];
      s.gyro_rate   = corner_vals[3 - i];
      send_sample(s);
    end

    // zero noise and step: covariance collapses, then zero innovation variance
    settle();
    program_regs('0, '0, '0, '0);
    for (int i = 0; i < 4; i++) begin
      s.accel_angle = corner_vals[(i + 1) % 4];
      s.gyro_rate   = corner_vals[i];
      send_sample(s);
    end

    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      settle();
      case (seg / 2)
        0: begin send_idle_pct = 9;  recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 9;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (seg)
        0: program_regs(PNA_RST, PNB_RST, MN_RST, DT_RST);
        2: program_regs($urandom, $urandom, $urandom, $urandom);
        4: program_regs(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
        default: program_regs($urandom_range(0, 42949673), $urandom_range(0, 42949673),
                              $urandom_range(1, 32'h7FFF_FFFF),
                              $urandom_range(4294967, 85899346));
      endcase
      for (int n = 0; n < SEG_ITEMS; n++)
        send_sample(next_sample());
    end

    settle();
    repeat (150) @(posedge clk);
    if (book.mismatches == 0 && book.fused_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
